### sv/rtp_h264_payload_to_annexb_macros.svh
// assertion macros for the rtp h264 payload to annex b converter
`ifndef RTP_H264_PAYLOAD_TO_ANNEXB_MACROS_SVH
`define RTP_H264_PAYLOAD_TO_ANNEXB_MACROS_SVH

`ifndef SYNTHESIS

// clocked property, disabled while reset is high
`define RTP2AB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rtp2ab assertion failed");

// clocked property checked during reset as well
`define RTP2AB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rtp2ab assertion failed");

`else

`define RTP2AB_ASSERT(lbl, clk, rst, prop)
`define RTP2AB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### sv/rtp2ab_pkg.sv
// shared types and constants of the rtp h264 payload to annex b converter
package rtp2ab_pkg;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // annex b start code
   localparam int START_LEN = 4;
   localparam logic [7:0] START_CODE [START_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

   // one command from the classifier to the emitter
   typedef struct packed {
      logic       with_start;  // emit start code before data
      logic [7:0] data;
      logic       byte_valid;  // 0 for an empty end marker
      logic       nal_end;
   } cmd_type;

endpackage

### sv/rtp_h264_payload_to_annexb.sv
// top level of the rtp h264 payload to annex b converter
// converts rtp h264 payload bytes into an annex b byte stream
// input side is a queue write port: a transaction moves on a clock edge with
// push high and full low, carrying one payload byte and its first and last
// of packet marks
// result side is a queue read port: while empty is low the oldest result is
// on the rsp_ ports and a transaction moves on an edge with pop high
// each payload byte gives zero to five results; run_last marks the final one
// a classifier front end updates packet state once per accepted byte and
// writes at most one command into a small queue; the emitter back end turns
// each command into one result per cycle while pop keeps the output moving,
// or five results when a start code leads; a byte's command is written into
// the queue and then loaded into the output register; packet bodies pass
// one byte per cycle while the receiver pops, and a start code adds its four
// bytes per nal unit; when the receiver stalls the output register holds,
// the queue fills and full rises; the front end keeps accepting until then
// reset clears packet state, the queue and the output register's full flag
module rtp_h264_payload_to_annexb #(
   parameter int QUEUE_DEPTH = rtp2ab_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_payload_byte,
   input  logic       req_first_of_packet,
   input  logic       req_last_of_packet,
   // result channel
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_nal_end,
   output logic       rsp_run_last
);
   import rtp2ab_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd_wr;
   cmd_type cmd_head;
   logic    cmd_valid;
   logic    cmd_pop;

   // transaction on the input side
   assign accept = push & ~full;

   // classify bytes and build commands
   rtp2ab_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .payload_byte    (req_payload_byte),
      .first_of_packet (req_first_of_packet),
      .last_of_packet  (req_last_of_packet),
      .cmd_push        (cmd_push),
      .cmd             (cmd_wr)
   );

   // decouples the front end from start code expansion stalls
   rtp2ab_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_push),
      .wr_data  (cmd_wr),
      .full     (full),
      .rd_en    (cmd_pop),
      .rd_data  (cmd_head),
      .rd_valid (cmd_valid)
   );

   // expand commands into result transactions
   rtp2ab_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd_head),
      .cmd_pop    (cmd_pop),
      .pop        (pop),
      .empty      (empty),
      .out_byte   (rsp_out_byte),
      .byte_valid (rsp_byte_valid),
      .nal_end    (rsp_nal_end),
      .run_last   (rsp_run_last)
   );

endmodule

### sv/rtp2ab_front.sv
// packet classifier: tracks packet position and builds emit commands
module rtp2ab_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          payload_byte,
   input  logic                first_of_packet,
   input  logic                last_of_packet,
   output logic                cmd_push,
   output rtp2ab_pkg::cmd_type cmd
);
   import rtp2ab_pkg::*;

   localparam logic [4:0] NAL_FRAG_UNIT = 5'd28;
   localparam logic [4:0] NAL_AGGREGATE = 5'd24;

   typedef enum logic [2:0] {
      POS_FIRST  = 3'b001,
      POS_FU_HDR = 3'b010,
      POS_BODY   = 3'b100
   } pos_type;

   typedef enum logic [2:0] {
      KIND_SINGLE = 3'b001,
      KIND_FU     = 3'b010,
      KIND_DROP   = 3'b100
   } kind_type;

   pos_type    pos_ff, pos_in;
   kind_type   kind_ff, kind_in;
   logic [2:0] f_nri_ff, f_nri_in;
   logic       end_flag_ff, end_flag_in;
   logic       has_cmd;
   logic       new_packet;
   logic [4:0] nal_type;

   assign nal_type = payload_byte[4:0];

   always_comb begin
      pos_in      = pos_ff;
      kind_in     = kind_ff;
      f_nri_in    = f_nri_ff;
      end_flag_in = end_flag_ff;
      has_cmd     = 1'b0;
      cmd         = '0;
      case (pos_ff)
         POS_FU_HDR, POS_BODY: new_packet = first_of_packet;
         default:              new_packet = 1'b1;
      endcase

      if (new_packet) begin
         if (nal_type == NAL_FRAG_UNIT) begin
            kind_in  = KIND_FU;
            f_nri_in = payload_byte[7:5];
            pos_in   = last_of_packet ? POS_FIRST : POS_FU_HDR;
         end else if (nal_type == NAL_AGGREGATE) begin
            kind_in = KIND_DROP;
            pos_in  = last_of_packet ? POS_FIRST : POS_BODY;
         end else begin
            kind_in        = KIND_SINGLE;
            has_cmd        = 1'b1;
            cmd.with_start = 1'b1;
            cmd.data       = payload_byte;
            cmd.byte_valid = 1'b1;
            cmd.nal_end    = last_of_packet;
            pos_in         = last_of_packet ? POS_FIRST : POS_BODY;
         end
      end else if (pos_ff == POS_FU_HDR) begin
         end_flag_in = payload_byte[6];
         if (payload_byte[7]) begin
            has_cmd        = 1'b1;
            cmd.with_start = 1'b1;
            cmd.data       = {f_nri_ff, nal_type};
            cmd.byte_valid = 1'b1;
            cmd.nal_end    = last_of_packet & payload_byte[6];
         end else if (last_of_packet && payload_byte[6]) begin
            // empty end marker
            has_cmd     = 1'b1;
            cmd.nal_end = 1'b1;
         end
         pos_in = last_of_packet ? POS_FIRST : POS_BODY;
      end else begin
         case (kind_ff)
            KIND_FU: begin
               has_cmd        = 1'b1;
               cmd.data       = payload_byte;
               cmd.byte_valid = 1'b1;
               cmd.nal_end    = last_of_packet & end_flag_ff;
            end
            KIND_SINGLE: begin
               has_cmd        = 1'b1;
               cmd.data       = payload_byte;
               cmd.byte_valid = 1'b1;
               cmd.nal_end    = last_of_packet;
            end
            default: has_cmd = 1'b0;
         endcase
         pos_in = last_of_packet ? POS_FIRST : POS_BODY;
      end
   end

   assign cmd_push = accept & has_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_FIRST;
         kind_ff     <= KIND_SINGLE;
         f_nri_ff    <= '0;
         end_flag_ff <= 1'b0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         kind_ff     <= kind_in;
         f_nri_ff    <= f_nri_in;
         end_flag_ff <= end_flag_in;
      end
   end

endmodule

### sv/rtp2ab_queue.sv
// short command queue between classifier and emitter
`include "rtp_h264_payload_to_annexb_macros.svh"

module rtp2ab_queue #(
   parameter int DEPTH = rtp2ab_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  rtp2ab_pkg::cmd_type wr_data,
   output logic                full,
   input  logic                rd_en,
   output rtp2ab_pkg::cmd_type rd_data,
   output logic                rd_valid
);
   import rtp2ab_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en & ~full;
   assign do_rd    = rd_en & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `RTP2AB_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH))
   `RTP2AB_ASSERT(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
   `RTP2AB_ASSERT(a_full_ptrs, clock, reset, full |-> (rd_ptr_ff == wr_ptr_ff))
   `RTP2AB_ASSERT(a_count_grow, clock, reset, (do_wr && !do_rd) |=> count_ff > $past(count_ff))

endmodule

### sv/rtp2ab_back.sv
// emitter: expands commands into result bytes behind an output register
`include "rtp_h264_payload_to_annexb_macros.svh"

module rtp2ab_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  rtp2ab_pkg::cmd_type cmd,
   output logic                cmd_pop,
   input  logic                pop,
   output logic                empty,
   output logic [7:0]          out_byte,
   output logic                byte_valid,
   output logic                nal_end,
   output logic                run_last
);
   import rtp2ab_pkg::*;

   localparam int STEP_W = $clog2(START_LEN + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              full_ff, full_in;
   logic [7:0]        byte_ff, byte_in;
   logic              valid_ff, valid_in;
   logic              end_ff, end_in;
   logic              last_ff, last_in;
   logic              load;
   logic              in_code;

   assign load    = cmd_valid & (~full_ff | pop);
   assign in_code = cmd.with_start & (step_ff != STEP_W'(START_LEN));

   always_comb begin
      step_in  = step_ff;
      byte_in  = byte_ff;
      valid_in = valid_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      cmd_pop  = 1'b0;
      full_in  = full_ff & ~pop;
      if (load) begin
         full_in = 1'b1;
         if (in_code) begin
            byte_in  = START_CODE[step_ff[$clog2(START_LEN)-1:0]];
            valid_in = 1'b1;
            end_in   = 1'b0;
            last_in  = 1'b0;
            step_in  = step_ff + 1'b1;
         end else begin
            byte_in  = cmd.data;
            valid_in = cmd.byte_valid;
            end_in   = cmd.nal_end;
            last_in  = 1'b1;
            step_in  = '0;
            cmd_pop  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      valid_ff <= valid_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
   end

   assign empty      = ~full_ff;
   assign out_byte   = byte_ff;
   assign byte_valid = valid_ff;
   assign nal_end    = end_ff;
   assign run_last   = last_ff;

   `RTP2AB_ASSERT(a_step_range, clock, reset, step_ff <= STEP_W'(START_LEN))
   `RTP2AB_ASSERT(a_step_head, clock, reset, (step_ff != '0) |-> (cmd_valid && cmd.with_start))
   `RTP2AB_ASSERT(a_pop_last, clock, reset, cmd_pop |=> (full_ff && last_ff))
   `RTP2AB_ASSERT(a_marker_ends, clock, reset, (full_ff && !valid_ff) |-> (end_ff && byte_ff == '0))

endmodule
